// ----- rtl/aob_pkg.sv -----
// shared types and constants for the argb over-blend pipeline
package aob_pkg;

   localparam int unsigned CHANNELS   = 3;
   localparam int unsigned PIPE_DEPTH = 6;
   localparam int unsigned ALPHA_POS  = 24;
   localparam int unsigned NUM_W      = 24;
   localparam int unsigned DIV_W      = 16;

   localparam logic [7:0]       FULL    = 8'd255;
   localparam logic [DIV_W-1:0] FULL_SQ = 16'd65025;

   // one item in the divider part of the pipe, channel 2 red, 1 green, 0 blue
   typedef struct packed {
      logic                             pass;
      logic [31:0]                      pass_pixel;
      logic [7:0]                       alpha;
      logic [DIV_W-1:0]                 divisor;
      logic [CHANNELS-1:0][NUM_W-1:0]   rem;
      logic [CHANNELS-1:0][7:0]         quo;
   } aob_div_type;

endpackage

// ----- rtl/aob_front.sv -----
// first two pipe stages: special cases, weights, divisor, alpha and numerators
module aob_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic [31:0]          fg_pixel,
   input  logic [31:0]          bg_pixel,
   output logic                 out_valid,
   input  logic                 out_stall,
   output aob_pkg::aob_div_type out_data
);

   typedef struct packed {
      logic                               pass;
      logic [31:0]                        pass_pixel;
      logic [15:0]                        prod;
      logic [15:0]                        wb;
      logic [15:0]                        wf;
      logic [aob_pkg::CHANNELS-1:0][7:0]  fg_col;
      logic [aob_pkg::CHANNELS-1:0][7:0]  bg_col;
   } aob_weight_type;

   logic                 s1_valid_ff, s1_valid_in;
   aob_weight_type       s1_data_ff, s1_data_in;
   logic                 s2_valid_ff, s2_valid_in;
   aob_pkg::aob_div_type s2_data_ff, s2_data_in;
   logic                 s1_stall, s2_stall;

   logic [7:0]  af, ab, tf, tb;
   logic [16:0] quot_sum;

   assign s2_stall = s2_valid_ff && out_stall;
   assign s1_stall = s1_valid_ff && s2_stall;
   assign in_stall = s1_stall;

   always_comb begin
      af = fg_pixel[aob_pkg::ALPHA_POS +: 8];
      ab = bg_pixel[aob_pkg::ALPHA_POS +: 8];
      tf = aob_pkg::FULL - af;
      tb = aob_pkg::FULL - ab;
      s1_data_in.pass = (af == aob_pkg::FULL) || (ab == 8'd0) || (af == 8'd0);
      // opaque foreground or empty background keeps the foreground
      s1_data_in.pass_pixel = ((af == aob_pkg::FULL) || (ab == 8'd0)) ? fg_pixel : bg_pixel;
      s1_data_in.prod = 16'(tf) * 16'(tb);
      s1_data_in.wb   = 16'(tf) * 16'(ab);
      s1_data_in.wf   = 16'(aob_pkg::FULL) * 16'(af);
      for (int c = 0; c < aob_pkg::CHANNELS; c++) begin
         s1_data_in.fg_col[c] = fg_pixel[8*c +: 8];
         s1_data_in.bg_col[c] = bg_pixel[8*c +: 8];
      end
      s1_valid_in = s1_stall ? s1_valid_ff : in_valid;
   end

   always_comb begin
      s2_data_in.pass       = s1_data_ff.pass;
      s2_data_in.pass_pixel = s1_data_ff.pass_pixel;
      s2_data_in.divisor    = aob_pkg::FULL_SQ - s1_data_ff.prod;
      // floor(prod / 255) for prod up to 255 * 255
      quot_sum = 17'(s1_data_ff.prod) + 17'd1 + 17'(s1_data_ff.prod[15:8]);
      s2_data_in.alpha = aob_pkg::FULL - quot_sum[15:8];
      for (int c = 0; c < aob_pkg::CHANNELS; c++) begin
         s2_data_in.rem[c] = 24'(s1_data_ff.wb) * 24'(s1_data_ff.bg_col[c])
                           + 24'(s1_data_ff.wf) * 24'(s1_data_ff.fg_col[c]);
         s2_data_in.quo[c] = 8'd0;
      end
      s2_valid_in = s2_stall ? s2_valid_ff : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!s1_stall) begin
         s1_data_ff <= s1_data_in;
      end
      if (!s2_stall) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// ----- rtl/aob_div_step.sv -----
// one divider stage: two restoring quotient bits per channel
module aob_div_step #(
   parameter int unsigned HIGH_BIT = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  aob_pkg::aob_div_type in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output aob_pkg::aob_div_type out_data
);

   logic                 valid_ff, valid_in;
   aob_pkg::aob_div_type data_ff, data_in;

   assign in_stall = valid_ff && out_stall;

   always_comb begin
      logic [aob_pkg::NUM_W-1:0] trial;
      data_in = in_data;
      trial   = '0;
      for (int c = 0; c < aob_pkg::CHANNELS; c++) begin
         for (int k = 0; k < 2; k++) begin
            trial = aob_pkg::NUM_W'(in_data.divisor) << (HIGH_BIT - k);
            if (data_in.rem[c] >= trial) begin
               data_in.rem[c] = data_in.rem[c] - trial;
               data_in.quo[c][HIGH_BIT - k] = 1'b1;
            end
         end
      end
      valid_in = in_stall ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/argb_over_alpha_blend_top.sv -----
// top level of the argb over-blend pipeline
// Porter-Duff over of two non-premultiplied ARGB8888 pixels. One pixel pair is
// taken every clock cycle unless req_stall is high; each result passes the
// front and division stages in order, waiting only while rsp_stall holds it.
// Two stages compute weights, divisor, alpha and the channel numerators, then
// four stages of restoring division produce two quotient bits per channel each.
// A stalled pipe fills its empty stages before it stalls the request side.
module argb_over_alpha_blend_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_fg_pixel,
   input  logic [31:0] req_bg_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_pixel
);

   localparam int unsigned STEPS = 4;

   logic                 valid_q [STEPS+1];
   logic                 stall_q [STEPS+1];
   aob_pkg::aob_div_type data_q  [STEPS+1];

   aob_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .fg_pixel  (req_fg_pixel),
      .bg_pixel  (req_bg_pixel),
      .out_valid (valid_q[0]),
      .out_stall (stall_q[0]),
      .out_data  (data_q[0])
   );

   for (genvar s = 0; s < STEPS; s++) begin : g_div
      aob_div_step #(
         .HIGH_BIT (7 - 2*s)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_q[s]),
         .in_stall  (stall_q[s]),
         .in_data   (data_q[s]),
         .out_valid (valid_q[s+1]),
         .out_stall (stall_q[s+1]),
         .out_data  (data_q[s+1])
      );
   end

   assign stall_q[STEPS] = rsp_stall;
   assign rsp_valid      = valid_q[STEPS];

   always_comb begin
      if (data_q[STEPS].pass) begin
         rsp_out_pixel = data_q[STEPS].pass_pixel;
      end else begin
         rsp_out_pixel = {data_q[STEPS].alpha, data_q[STEPS].quo[2],
                          data_q[STEPS].quo[1], data_q[STEPS].quo[0]};
      end
   end

endmodule

// ----- rtl/aob_checker.sv -----
// port-level checks for the argb over-blend pipeline and their bind
module aob_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_out_pixel
);

   logic [2:0] count_ff, count_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff + 3'(req_xfer) - 3'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_pixel))
      else $error("stalled result changed");

   // items in flight never exceed the pipe depth
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(aob_pkg::PIPE_DEPTH))
      else $error("more items in flight than pipe stages");

   // request side stalls only with a full pipe held by the result side
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_stall && count_ff == 3'(aob_pkg::PIPE_DEPTH))
      else $error("request stalled with free pipe stages");

   // no result without an item in flight
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != 3'd0)
      else $error("result shown with no item in flight");

endmodule

bind argb_over_alpha_blend_top aob_checker u_aob_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_pixel (rsp_out_pixel)
);
